// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that stays armed through reset.
`define CFA_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/cfa_pkg.sv =====
// Package: operation codes, status codes, pipeline payload and divider step.
package cfa_pkg;

  localparam int DataW        = 16;
  localparam int CmdW         = 5;
  localparam int StatusW      = 2;
  localparam int DivStages    = 4;
  localparam int BitsPerStage = DataW / DivStages;

  localparam logic [CmdW-1:0] CMD_ADD = 5'd0;
  localparam logic [CmdW-1:0] CMD_SUB = 5'd1;
  localparam logic [CmdW-1:0] CMD_MUL = 5'd2;
  localparam logic [CmdW-1:0] CMD_DIV = 5'd3;
  localparam logic [CmdW-1:0] CMD_MOD = 5'd4;
  localparam logic [CmdW-1:0] CMD_AND = 5'd5;
  localparam logic [CmdW-1:0] CMD_OR  = 5'd6;
  localparam logic [CmdW-1:0] CMD_XOR = 5'd7;
  localparam logic [CmdW-1:0] CMD_NEG = 5'd8;
  localparam logic [CmdW-1:0] CMD_CPL = 5'd9;
  localparam logic [CmdW-1:0] CMD_SHL = 5'd10;
  localparam logic [CmdW-1:0] CMD_SHR = 5'd11;
  localparam logic [CmdW-1:0] CMD_EQ  = 5'd12;
  localparam logic [CmdW-1:0] CMD_NE  = 5'd13;
  localparam logic [CmdW-1:0] CMD_LT  = 5'd14;
  localparam logic [CmdW-1:0] CMD_GT  = 5'd15;
  localparam logic [CmdW-1:0] CMD_LE  = 5'd16;
  localparam logic [CmdW-1:0] CMD_GE  = 5'd17;
  localparam logic [CmdW-1:0] CMD_SEL = 5'd18;

  localparam logic [StatusW-1:0] ST_FOLDED = 2'd0;
  localparam logic [StatusW-1:0] ST_DIVCHK = 2'd1;
  localparam logic [StatusW-1:0] ST_NOFOLD = 2'd2;

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    logic                is_div;
    logic                is_mod;
    logic [StatusW-1:0]  status;
    word_t               value;
    word_t               rem;
    word_t               quo;
    word_t               dvsr;
    logic                neg_q;
    logic                neg_r;
  } pipe_t;

  // BitsPerStage restoring-division steps: the dividend shifts out of quo while
  // quotient bits shift in behind it.
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t          o;
    logic [DataW:0] trial;
    o = p;
    for (int i = 0; i < BitsPerStage; i++) begin
      trial = {o.rem, o.quo[DataW-1]};
      o.quo = {o.quo[DataW-2:0], 1'b0};
      if (trial >= {1'b0, o.dvsr}) begin
        trial    = trial - {1'b0, o.dvsr};
        o.quo[0] = 1'b1;
      end
      o.rem = trial[DataW-1:0];
    end
    return o;
  endfunction

endpackage

// ===== rtl/cfa_if.sv =====
// Channel interfaces for the operand and result streams.
interface cfa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [cfa_pkg::CmdW-1:0]      cmd;
  logic signed [cfa_pkg::DataW-1:0]     lhs_value;
  logic signed [cfa_pkg::DataW-1:0]     rhs_value;
  logic signed [cfa_pkg::DataW-1:0]     else_value;
  logic                                 lhs_unsigned;
  logic                                 rhs_unsigned;

  modport source (output valid, cmd, lhs_value, rhs_value, else_value, lhs_unsigned,
                  rhs_unsigned, input ready);
  modport sink (input valid, cmd, lhs_value, rhs_value, else_value, lhs_unsigned,
                rhs_unsigned, output ready);
endinterface

interface cfa_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cfa_pkg::DataW-1:0]     result_value;
  logic        [cfa_pkg::StatusW-1:0]   fold_status;

  modport source (output valid, result_value, fold_status, input ready);
  modport sink (input valid, result_value, fold_status, output ready);
endinterface

// ===== rtl/cfa_front.sv =====
// First stage: decode, the operations that need no divider (multiply among them) and divider setup.
module cfa_front (
  input  logic           clk,
  input  logic           rst_n,
  cfa_in_if.sink         in_ch,
  output logic           out_valid,
  output cfa_pkg::pipe_t out_data,
  input  logic           out_ready
);
  import cfa_pkg::*;

  logic  valid_r, valid_nxt;
  pipe_t data_r, data_nxt;
  logic  stage_ready;

  word_t ua, ub, uc;
  logic  uns, a_neg, b_neg, big_shift;
  word_t mag_a, mag_b;

  assign stage_ready = !valid_r || out_ready;
  assign in_ch.ready = stage_ready;
  assign out_valid   = valid_r;
  assign out_data    = data_r;

  always_comb begin
    ua        = in_ch.lhs_value;
    ub        = in_ch.rhs_value;
    uc        = in_ch.else_value;
    uns       = in_ch.lhs_unsigned || in_ch.rhs_unsigned;
    a_neg     = !uns && ua[DataW-1];
    b_neg     = !uns && ub[DataW-1];
    mag_a     = a_neg ? (~ua + word_t'(1)) : ua;
    mag_b     = b_neg ? (~ub + word_t'(1)) : ub;
    big_shift = |ub[DataW-1:$clog2(DataW)];

    data_nxt        = '0;
    data_nxt.status = ST_FOLDED;
    data_nxt.quo    = mag_a;
    data_nxt.dvsr   = mag_b;
    data_nxt.neg_q  = a_neg ^ b_neg;
    data_nxt.neg_r  = a_neg;

    unique case (in_ch.cmd)
      CMD_ADD: data_nxt.value = ua + ub;
      CMD_SUB: data_nxt.value = ua - ub;
      CMD_MUL: data_nxt.value = ua * ub;
      CMD_DIV, CMD_MOD: begin
        data_nxt.is_div = 1'b1;
        data_nxt.is_mod = (in_ch.cmd == CMD_MOD);
        if (ub == '0) begin
          data_nxt.status = ST_DIVCHK;
        end
      end
      CMD_AND: data_nxt.value = ua & ub;
      CMD_OR:  data_nxt.value = ua | ub;
      CMD_XOR: data_nxt.value = ua ^ ub;
      CMD_NEG: data_nxt.value = word_t'(0) - ua;
      CMD_CPL: data_nxt.value = ~ua;
      CMD_SHL: data_nxt.value = big_shift ? '0 : (ua << ub[$clog2(DataW)-1:0]);
      CMD_SHR: begin
        if (uns) begin
          data_nxt.value = big_shift ? '0 : (ua >> ub[$clog2(DataW)-1:0]);
        end else if (big_shift) begin
          data_nxt.value = {DataW{ua[DataW-1]}};
        end else begin
          data_nxt.value = word_t'($signed(ua) >>> ub[$clog2(DataW)-1:0]);
        end
      end
      CMD_EQ:  data_nxt.value = word_t'($signed(ua) == $signed(ub));
      CMD_NE:  data_nxt.value = word_t'($signed(ua) != $signed(ub));
      CMD_LT:  data_nxt.value = word_t'($signed(ua) <  $signed(ub));
      CMD_GT:  data_nxt.value = word_t'($signed(ua) >  $signed(ub));
      CMD_LE:  data_nxt.value = word_t'($signed(ua) <= $signed(ub));
      CMD_GE:  data_nxt.value = word_t'($signed(ua) >= $signed(ub));
      CMD_SEL: data_nxt.value = (ua != '0) ? ub : uc;
      default: data_nxt.status = ST_NOFOLD;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (stage_ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && stage_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/cfa_div_stage.sv =====
// One divider stage: a group of restoring steps with its own beat register.
module cfa_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  cfa_pkg::pipe_t in_data,
  output logic           in_ready,
  output logic           out_valid,
  output cfa_pkg::pipe_t out_data,
  input  logic           out_ready
);
  import cfa_pkg::*;

  logic  valid_r, valid_nxt;
  pipe_t data_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= div_step(in_data);
    end
  end

endmodule

// ===== rtl/cfa_back.sv =====
// Last stage: sign fix of quotient and remainder, result select, output register.
module cfa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  cfa_pkg::pipe_t in_data,
  output logic           in_ready,
  cfa_out_if.source      out_ch
);
  import cfa_pkg::*;

  logic               valid_r, valid_nxt;
  word_t              result_r, result_nxt;
  logic [StatusW-1:0] status_r;
  word_t              quo_fix, rem_fix;

  assign in_ready            = !valid_r || out_ch.ready;
  assign out_ch.valid        = valid_r;
  assign out_ch.result_value = result_r;
  assign out_ch.fold_status  = status_r;

  always_comb begin
    quo_fix = in_data.neg_q ? (~in_data.quo + word_t'(1)) : in_data.quo;
    rem_fix = in_data.neg_r ? (~in_data.rem + word_t'(1)) : in_data.rem;
    priority if (in_data.status != ST_FOLDED) begin
      result_nxt = '0;
    end else if (in_data.is_div) begin
      result_nxt = in_data.is_mod ? rem_fix : quo_fix;
    end else begin
      result_nxt = in_data.value;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result_r <= result_nxt;
      status_r <= in_data.status;
    end
  end

endmodule

// ===== rtl/const_fold_alu16.sv =====
// Top level of the 16-bit constant folding unit.
//
//   channel | dir | handshake            | beat contents
//   in_ch   | in  | valid/ready          | cmd, lhs/rhs/else values, unsigned flags
//   out_ch  | out | valid/ready          | result_value, fold_status
//
// One beat enters per cycle while the output is not stalled.
// The depth is set by the divider: four stages of four restoring steps each,
// between a decode stage and a sign-fix/output stage.
// Every stage has its own valid bit and takes a beat when it is empty or its
// successor takes its beat, so a stalled output fills bubbles upstream first.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module const_fold_alu16 (
  input  logic      clk,
  input  logic      rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch
);
  import cfa_pkg::*;

  logic  stg_valid [0:DivStages];
  logic  stg_ready [0:DivStages];
  pipe_t stg_data  [0:DivStages];

  cfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (stg_valid[0]),
    .out_data  (stg_data[0]),
    .out_ready (stg_ready[0])
  );

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    cfa_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[k]),
      .in_data   (stg_data[k]),
      .in_ready  (stg_ready[k]),
      .out_valid (stg_valid[k+1]),
      .out_data  (stg_data[k+1]),
      .out_ready (stg_ready[k+1])
    );
  end

  cfa_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (stg_valid[DivStages]),
    .in_data  (stg_data[DivStages]),
    .in_ready (stg_ready[DivStages]),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/cfa_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`include "assert_macros.svh"

module cfa_port_checks (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cfa_pkg::DataW-1:0]   result_value,
  input logic [cfa_pkg::StatusW-1:0] fold_status
);
  import cfa_pkg::*;

  // A stalled beat keeps its contents until it is taken.
  `CFA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(result_value) && $stable(fold_status))

  // Anything other than a folded value carries a zero result.
  `CFA_ASSERT_NOW(a_unfolded_zero, clk, rst_n, out_valid && (fold_status != ST_FOLDED),
    result_value == '0)

  // Reset empties the pipeline.
  `CFA_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind const_fold_alu16 cfa_port_checks u_cfa_port_checks (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .result_value (out_ch.result_value),
  .fold_status  (out_ch.fold_status)
);
